/* rtl/nps_pkg.sv */
// Shared constants, codes and types for the nearest palette color search block.
package nps_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    localparam int COLOR_W       = 24;
    localparam int CH_W          = 8;
    localparam int SQ_W          = 2 * CH_W;
    localparam int DIST_W        = 18;
    localparam int SIZE_W        = 9;
    localparam int ENTRY_W       = 8;
    localparam int OUT_IDX_W     = 8;

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] SIZE_DEPTH = SIZE_W'(PALETTE_DEPTH);
    localparam logic [DIST_W-1:0] DIST_NONE  = '1;

    // Register word select (paddr bit 2)
    localparam logic REG_PALETTE_SIZE = 1'b0;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
    } scan_tag_t;

endpackage

/* rtl/nps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/nps_dist.sv */
// Two-stage squared RGB distance pipeline with a travelling scan tag.
module nps_dist (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nps_pkg::scan_tag_t                  entry_tag,
    input  logic [nps_pkg::COLOR_W-1:0]         color,
    input  logic [nps_pkg::COLOR_W-1:0]         pixel,
    output nps_pkg::scan_tag_t                  dist_tag,
    output logic [nps_pkg::DIST_W-1:0]          sq_dist
);

    logic [nps_pkg::CH_W-1:0] d_r, d_g, d_b;
    logic [nps_pkg::SQ_W-1:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic [nps_pkg::DIST_W-1:0] dist_reg;
    nps_pkg::scan_tag_t       tag1_reg, tag2_reg;

    function automatic logic [nps_pkg::CH_W-1:0] abs_diff(
        input logic [nps_pkg::CH_W-1:0] a,
        input logic [nps_pkg::CH_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign d_r = abs_diff(color[23:16], pixel[23:16]);
    assign d_g = abs_diff(color[15:8],  pixel[15:8]);
    assign d_b = abs_diff(color[7:0],   pixel[7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= entry_tag;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= nps_pkg::SQ_W'(d_r) * nps_pkg::SQ_W'(d_r);
        sq_g_reg <= nps_pkg::SQ_W'(d_g) * nps_pkg::SQ_W'(d_g);
        sq_b_reg <= nps_pkg::SQ_W'(d_b) * nps_pkg::SQ_W'(d_b);
        dist_reg <= nps_pkg::DIST_W'(sq_r_reg) + nps_pkg::DIST_W'(sq_g_reg)
                  + nps_pkg::DIST_W'(sq_b_reg);
    end

    assign dist_tag = tag2_reg;
    assign sq_dist  = dist_reg;

endmodule

/* rtl/nearest_palette_color_search_unit.sv */
// Top level: palette store, scan sequencer, best-match tracking and APB register.
//
// Input channel px_*: each item is a palette write (action 0) or a pixel lookup
// (action 1). An item is taken when px_valid is high and px_stall is low.
// A write stores rgb_color at entry_index and gives no result; entries at or
// beyond the palette depth are dropped.
// A lookup reads one palette entry per cycle from the palette RAM, entries 0 to
// min(palette_size, depth)-1, through a two-stage distance pipeline, and keeps
// the first entry with the smallest squared distance. It stalls the input until
// its result is loaded into the output register. An empty palette answers with
// index 0 and distance all ones. The single RAM read port sets the rate: one
// entry per cycle.
// Output channel res_*: one item per lookup, held in an output register; a new
// input item is taken while a result still waits. If res_stall holds the
// previous result, the finished lookup waits before the output register.
// palette_size is written over APB at byte address 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset clears the palette to black (per-entry valid bits) and sets
// palette_size to 256; no clearing pass is needed.
module nearest_palette_color_search_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 px_valid,
    output logic                                 px_stall,
    input  logic [0:0]                           action,
    input  logic [nps_pkg::ENTRY_W-1:0]          entry_index,
    input  logic [nps_pkg::COLOR_W-1:0]          rgb_color,

    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [nps_pkg::OUT_IDX_W-1:0]        best_index,
    output logic [nps_pkg::DIST_W-1:0]           best_distance,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nps_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [nps_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [nps_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [nps_pkg::SIZE_W-1:0]      size_reg;
    logic [nps_pkg::CNT_W-1:0]       count_reg;
    logic [nps_pkg::CNT_W-1:0]       cnt_reg;
    logic                            issue_reg;
    logic                            first_reg;
    logic [nps_pkg::COLOR_W-1:0]     pixel_reg;
    logic [nps_pkg::IDX_W-1:0]       best_idx_reg;
    logic [nps_pkg::DIST_W-1:0]      best_dist_reg;
    logic                            res_valid_reg;
    logic [nps_pkg::OUT_IDX_W-1:0]   res_idx_reg;
    logic [nps_pkg::DIST_W-1:0]      res_dist_reg;

    logic [nps_pkg::PALETTE_DEPTH-1:0] vld_reg;
    logic                            ent_vld_reg;
    nps_pkg::scan_tag_t              rt_reg;

    logic                            px_accept;
    logic                            is_lookup;
    logic                            entry_ok;
    logic                            wr_en;
    logic                            rd_en;
    logic                            rd_last;
    logic [nps_pkg::IDX_W-1:0]       rd_addr;
    logic [nps_pkg::IDX_W-1:0]       wr_addr;
    logic [nps_pkg::SIZE_W-1:0]      size_clamp;
    logic [nps_pkg::CNT_W-1:0]       count_clamp;
    logic [nps_pkg::COLOR_W-1:0]     ram_rdata;
    logic [nps_pkg::COLOR_W-1:0]     ent_color;
    nps_pkg::scan_tag_t              rd_tag;
    nps_pkg::scan_tag_t              dq_tag;
    logic [nps_pkg::DIST_W-1:0]      dq_dist;
    logic                            upd;
    logic                            res_take;
    logic                            cfg_wr;

    assign px_stall    = (state_reg != ST_IDLE);
    assign px_accept   = px_valid && !px_stall;
    assign is_lookup   = (action == nps_pkg::ACT_LOOKUP);
    assign entry_ok    = ({1'b0, entry_index} < nps_pkg::SIZE_DEPTH);
    assign wr_en       = px_accept && !is_lookup && entry_ok;
    assign wr_addr     = entry_index[nps_pkg::IDX_W-1:0];

    assign size_clamp  = (size_reg > nps_pkg::SIZE_DEPTH) ? nps_pkg::SIZE_DEPTH : size_reg;
    assign count_clamp = nps_pkg::CNT_W'(size_clamp);

    assign rd_en       = (state_reg == ST_SCAN) && issue_reg;
    assign rd_addr     = cnt_reg[nps_pkg::IDX_W-1:0];
    assign rd_last     = (cnt_reg == count_reg - nps_pkg::CNT_W'(1));

    assign res_take    = res_valid_reg && !res_stall;
    assign upd         = first_reg || (dq_dist < best_dist_reg);

    assign cfg_wr      = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == nps_pkg::REG_PALETTE_SIZE)
                       ? nps_pkg::APB_DATA_W'(size_reg) : '0;

    nps_ram #(
        .WIDTH (nps_pkg::COLOR_W),
        .DEPTH (nps_pkg::PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (rgb_color),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= nps_pkg::SIZE_RESET;
        end
        else if (cfg_wr && (paddr[2] == nps_pkg::REG_PALETTE_SIZE))
        begin
            size_reg <= pwdata[nps_pkg::SIZE_W-1:0];
        end
    end

    // Entries never written read as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rt_reg <= rd_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ent_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_tag    = '{vld: rd_en, last: rd_last, idx: rd_addr};
    assign ent_color = ent_vld_reg ? ram_rdata : '0;

    nps_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .entry_tag (rt_reg),
        .color     (ent_color),
        .pixel     (pixel_reg),
        .dist_tag  (dq_tag),
        .sq_dist   (dq_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            first_reg     <= 1'b1;
            pixel_reg     <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
            res_valid_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_dist_reg  <= '0;
        end
        else
        begin
            if (res_take && (state_reg != ST_DONE))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (px_accept && is_lookup)
                    begin
                        pixel_reg     <= rgb_color;
                        count_reg     <= count_clamp;
                        cnt_reg       <= '0;
                        first_reg     <= 1'b1;
                        best_idx_reg  <= '0;
                        best_dist_reg <= nps_pkg::DIST_NONE;
                        if (count_clamp == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            issue_reg <= 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        cnt_reg <= cnt_reg + nps_pkg::CNT_W'(1);
                        if (rd_last)
                        begin
                            issue_reg <= 1'b0;
                        end
                    end
                    if (dq_tag.vld)
                    begin
                        if (upd)
                        begin
                            best_idx_reg  <= dq_tag.idx;
                            best_dist_reg <= dq_dist;
                            first_reg     <= 1'b0;
                        end
                        if (dq_tag.last)
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_valid_reg <= 1'b1;
                        res_idx_reg   <= nps_pkg::OUT_IDX_W'(best_idx_reg);
                        res_dist_reg  <= best_dist_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign res_valid     = res_valid_reg;
    assign best_index    = res_idx_reg;
    assign best_distance = res_dist_reg;

    a_dist_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dq_tag.vld |-> (state_reg == ST_SCAN))
        else $error("distance result outside of a scan");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (cnt_reg < count_reg))
        else $error("palette read beyond searched size");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished lookup");

    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && count_reg != '0) |-> (best_dist_reg <= 18'd195075))
        else $error("best distance out of range after a scan");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("palette write during a scan");

endmodule
